### hdl/cubic_bezier_evaluator_defines.svh
// ----------------------------------------------------------------------------
// cubic bezier evaluator assertion macros
// concurrent property shorthands used by the evaluator top level
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EVALUATOR_DEFINES_SVH
`define CUBIC_BEZIER_EVALUATOR_DEFINES_SVH

// consequent checked in the same cycle
`define CBE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// shared widths, register indexes and pipeline control type of the cubic
// bezier evaluator
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int T_FRAC_BITS_DEF = 16;

    localparam int T_W       = 17;
    localparam int PNT_W     = 32;
    localparam int POS_W     = 32;
    localparam int VEL_W     = 36;
    localparam int ACC_W     = 38;
    localparam int COEF_A_W  = 35;
    localparam int COEF_B_W  = 36;
    localparam int COEF_C_W  = 35;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam int NUM_STAGES = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CTRL0_X = 8'd0,
        CFG_CTRL0_Y = 8'd1,
        CFG_CTRL1_X = 8'd2,
        CFG_CTRL1_Y = 8'd3,
        CFG_CTRL2_X = 8'd4,
        CFG_CTRL2_Y = 8'd5,
        CFG_CTRL3_X = 8'd6,
        CFG_CTRL3_Y = 8'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

### hdl/cbe_pipe.sv
// ----------------------------------------------------------------------------
// cbe_pipe
// valid bits and per-stage load enables of the evaluator pipeline; a stage
// loads whenever it is empty or the stage after it moves, so bubbles close up
// behind a held result
// ----------------------------------------------------------------------------
module cbe_pipe
    import cbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] rdy;

    always_comb begin
        rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !rdy[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_ctl.load  = rdy;
    assign o_ctl.vld   = r_vld;

endmodule

### hdl/cbe_axis.sv
// ----------------------------------------------------------------------------
// cbe_axis
// seven-stage datapath for one axis: power-basis coefficients, horner
// multiplies by t with exact products, and one round-to-nearest per result
// ----------------------------------------------------------------------------
module cbe_axis
    import cbe_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  logic signed [PNT_W-1:0]  i_p0,
    input  logic signed [PNT_W-1:0]  i_p1,
    input  logic signed [PNT_W-1:0]  i_p2,
    input  logic signed [PNT_W-1:0]  i_p3,
    input  logic        [T_W-1:0]    i_u,
    output logic signed [POS_W-1:0]  o_pos,
    output logic signed [VEL_W-1:0]  o_vel,
    output logic signed [ACC_W-1:0]  o_acc
);

    localparam int F   = T_FRAC_BITS;
    localparam int UW  = T_W + 1;
    localparam int MW  = COEF_A_W + UW;
    localparam int H1W = 37 + F;
    localparam int V1W = 38 + F;
    localparam int ANW = 39 + F;
    localparam int M2W = H1W + UW;
    localparam int MVW = V1W + UW;
    localparam int H2W = 38 + 2 * F;
    localparam int V2W = 39 + 2 * F;
    localparam int M3W = H2W + UW;
    localparam int PNW = 39 + 3 * F;

    localparam logic signed [ANW-1:0] ACC_HALF = ANW'(1) <<< (F - 1);
    localparam logic signed [V2W-1:0] VEL_HALF = V2W'(1) <<< (2 * F - 1);
    localparam logic signed [PNW-1:0] POS_HALF = PNW'(1) <<< (3 * F - 1);

    // stage 1: coefficients
    logic signed [COEF_A_W-1:0] r_s1_a, n_a;
    logic signed [COEF_B_W-1:0] r_s1_b, n_b;
    logic signed [COEF_C_W-1:0] r_s1_c, n_c;
    logic signed [PNT_W-1:0]    r_s1_d;
    logic        [T_W-1:0]      r_s1_u;

    // stage 2: a * u
    logic signed [MW-1:0]       r_s2_m, n_m;
    logic signed [COEF_B_W-1:0] r_s2_b;
    logic signed [COEF_C_W-1:0] r_s2_c;
    logic signed [PNT_W-1:0]    r_s2_d;
    logic        [T_W-1:0]      r_s2_u;

    // stage 3: first horner sums, acceleration rounded
    logic signed [H1W-1:0]      r_s3_h1, n_h1;
    logic signed [V1W-1:0]      r_s3_v1, n_v1;
    logic signed [ANW-1:0]      acc_sum;
    logic signed [ACC_W-1:0]    r_s3_acc;
    logic signed [COEF_C_W-1:0] r_s3_c;
    logic signed [PNT_W-1:0]    r_s3_d;
    logic        [T_W-1:0]      r_s3_u;

    // stage 4: second multiplies
    logic signed [M2W-1:0]      r_s4_m2, n_m2;
    logic signed [MVW-1:0]      r_s4_mv, n_mv;
    logic signed [ACC_W-1:0]    r_s4_acc;
    logic signed [COEF_C_W-1:0] r_s4_c;
    logic signed [PNT_W-1:0]    r_s4_d;
    logic        [T_W-1:0]      r_s4_u;

    // stage 5: second horner sums, velocity rounded
    logic signed [H2W-1:0]      r_s5_h2, n_h2;
    logic signed [V2W-1:0]      vel_sum;
    logic signed [VEL_W-1:0]    r_s5_vel;
    logic signed [ACC_W-1:0]    r_s5_acc;
    logic signed [PNT_W-1:0]    r_s5_d;
    logic        [T_W-1:0]      r_s5_u;

    // stage 6: third multiply
    logic signed [M3W-1:0]      r_s6_m3, n_m3;
    logic signed [VEL_W-1:0]    r_s6_vel;
    logic signed [ACC_W-1:0]    r_s6_acc;
    logic signed [PNT_W-1:0]    r_s6_d;

    // stage 7: position rounded
    logic signed [PNW-1:0]      pos_sum;
    logic signed [POS_W-1:0]    r_s7_pos;
    logic signed [VEL_W-1:0]    r_s7_vel;
    logic signed [ACC_W-1:0]    r_s7_acc;

    logic signed [UW-1:0] u2_s, u4_s, u6_s;

    always_comb begin
        n_a = COEF_A_W'(i_p3) - COEF_A_W'(i_p0)
            + (COEF_A_W'(i_p1) <<< 1) + COEF_A_W'(i_p1)
            - (COEF_A_W'(i_p2) <<< 1) - COEF_A_W'(i_p2);
        n_b = (COEF_B_W'(i_p0) <<< 1) + COEF_B_W'(i_p0)
            - (COEF_B_W'(i_p1) <<< 2) - (COEF_B_W'(i_p1) <<< 1)
            + (COEF_B_W'(i_p2) <<< 1) + COEF_B_W'(i_p2);
        n_c = (COEF_C_W'(i_p1) <<< 1) + COEF_C_W'(i_p1)
            - (COEF_C_W'(i_p0) <<< 1) - COEF_C_W'(i_p0);
    end

    assign u2_s = $signed({1'b0, r_s1_u});
    assign u4_s = $signed({1'b0, r_s3_u});
    assign u6_s = $signed({1'b0, r_s5_u});

    assign n_m  = MW'(r_s1_a) * MW'(u2_s);

    always_comb begin
        n_h1    = H1W'(r_s2_m) + (H1W'(r_s2_b) <<< F);
        n_v1    = (V1W'(r_s2_m) <<< 1) + V1W'(r_s2_m) + (V1W'(r_s2_b) <<< (F + 1));
        acc_sum = (ANW'(r_s2_m) <<< 2) + (ANW'(r_s2_m) <<< 1)
                + (ANW'(r_s2_b) <<< (F + 1)) + ACC_HALF;
    end

    assign n_m2 = M2W'(r_s3_h1) * M2W'(u4_s);
    assign n_mv = MVW'(r_s3_v1) * MVW'(u4_s);

    always_comb begin
        n_h2    = H2W'(r_s4_m2) + (H2W'(r_s4_c) <<< (2 * F));
        vel_sum = V2W'(r_s4_mv) + (V2W'(r_s4_c) <<< (2 * F)) + VEL_HALF;
    end

    assign n_m3    = M3W'(r_s5_h2) * M3W'(u6_s);
    assign pos_sum = PNW'(r_s6_m3) + (PNW'(r_s6_d) <<< (3 * F)) + POS_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_s1_a <= n_a;
            r_s1_b <= n_b;
            r_s1_c <= n_c;
            r_s1_d <= i_p0;
            r_s1_u <= i_u;
        end
        if (i_ctl.load[1]) begin
            r_s2_m <= n_m;
            r_s2_b <= r_s1_b;
            r_s2_c <= r_s1_c;
            r_s2_d <= r_s1_d;
            r_s2_u <= r_s1_u;
        end
        if (i_ctl.load[2]) begin
            r_s3_h1  <= n_h1;
            r_s3_v1  <= n_v1;
            r_s3_acc <= acc_sum[F+ACC_W-1:F];
            r_s3_c   <= r_s2_c;
            r_s3_d   <= r_s2_d;
            r_s3_u   <= r_s2_u;
        end
        if (i_ctl.load[3]) begin
            r_s4_m2  <= n_m2;
            r_s4_mv  <= n_mv;
            r_s4_acc <= r_s3_acc;
            r_s4_c   <= r_s3_c;
            r_s4_d   <= r_s3_d;
            r_s4_u   <= r_s3_u;
        end
        if (i_ctl.load[4]) begin
            r_s5_h2  <= n_h2;
            r_s5_vel <= vel_sum[2*F+VEL_W-1:2*F];
            r_s5_acc <= r_s4_acc;
            r_s5_d   <= r_s4_d;
            r_s5_u   <= r_s4_u;
        end
        if (i_ctl.load[5]) begin
            r_s6_m3  <= n_m3;
            r_s6_vel <= r_s5_vel;
            r_s6_acc <= r_s5_acc;
            r_s6_d   <= r_s5_d;
        end
        if (i_ctl.load[6]) begin
            r_s7_pos <= pos_sum[3*F+POS_W-1:3*F];
            r_s7_vel <= r_s6_vel;
            r_s7_acc <= r_s6_acc;
        end
    end

    assign o_pos = r_s7_pos;
    assign o_vel = r_s7_vel;
    assign o_acc = r_s7_acc;

endmodule

### hdl/cubic_bezier_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_evaluator
// Evaluates a 2-D cubic Bezier segment at curve parameter t (unsigned
// Q1.16, values above 1.0 are clamped to 1.0) and returns position
// (Q16.16), first derivative and second derivative (Q.16) for x and y, each
// rounded once to nearest with ties toward plus infinity. The four control
// points are written through the configuration port, which always accepts;
// indexes above 7 are ignored. A new transaction is accepted every cycle
// unless o_stall is high, which it is only while a result is held and the
// pipeline behind it is full. The 7-stage pipeline loads its first stage at
// the accepting edge and holds three registered multiplier stages per axis.
// While a result is held, earlier stages keep filling until the pipeline is full.
// ----------------------------------------------------------------------------
`include "cubic_bezier_evaluator_defines.svh"

module cubic_bezier_evaluator
    import cbe_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic        [T_W-1:0]    i_t_param,

    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [POS_W-1:0]  o_pos_x,
    output logic signed [POS_W-1:0]  o_pos_y,
    output logic signed [VEL_W-1:0]  o_vel_x,
    output logic signed [VEL_W-1:0]  o_vel_y,
    output logic signed [ACC_W-1:0]  o_acc_x,
    output logic signed [ACC_W-1:0]  o_acc_y,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data
);

    localparam longint unsigned T_ONE = 64'd1 << T_FRAC_BITS;

    logic signed [PNT_W-1:0] r_ctrl0_x, r_ctrl0_y;
    logic signed [PNT_W-1:0] r_ctrl1_x, r_ctrl1_y;
    logic signed [PNT_W-1:0] r_ctrl2_x, r_ctrl2_y;
    logic signed [PNT_W-1:0] r_ctrl3_x, r_ctrl3_y;

    logic [T_W-1:0] u_clamp;
    t_pipe_ctl      ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl0_x <= '0;
            r_ctrl0_y <= '0;
            r_ctrl1_x <= '0;
            r_ctrl1_y <= '0;
            r_ctrl2_x <= '0;
            r_ctrl2_y <= '0;
            r_ctrl3_x <= '0;
            r_ctrl3_y <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CTRL0_X: r_ctrl0_x <= i_cfg_data;
                CFG_CTRL0_Y: r_ctrl0_y <= i_cfg_data;
                CFG_CTRL1_X: r_ctrl1_x <= i_cfg_data;
                CFG_CTRL1_Y: r_ctrl1_y <= i_cfg_data;
                CFG_CTRL2_X: r_ctrl2_x <= i_cfg_data;
                CFG_CTRL2_Y: r_ctrl2_y <= i_cfg_data;
                CFG_CTRL3_X: r_ctrl3_x <= i_cfg_data;
                CFG_CTRL3_Y: r_ctrl3_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // t beyond one saturates to the segment end
    assign u_clamp = (64'(i_t_param) > T_ONE) ? T_W'(T_ONE) : i_t_param;

    cbe_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_ctl       (ctl)
    );

    cbe_axis #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_x (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_p0  (r_ctrl0_x),
        .i_p1  (r_ctrl1_x),
        .i_p2  (r_ctrl2_x),
        .i_p3  (r_ctrl3_x),
        .i_u   (u_clamp),
        .o_pos (o_pos_x),
        .o_vel (o_vel_x),
        .o_acc (o_acc_x)
    );

    cbe_axis #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_y (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_p0  (r_ctrl0_y),
        .i_p1  (r_ctrl1_y),
        .i_p2  (r_ctrl2_y),
        .i_p3  (r_ctrl3_y),
        .i_u   (u_clamp),
        .o_pos (o_pos_y),
        .o_vel (o_vel_y),
        .o_acc (o_acc_y)
    );

    `CBE_ASSERT_SAME(a_stall_only_when_held, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stall without a held result")
    `CBE_ASSERT_NEXT(a_accept_enters_stage1, i_clk, i_rst_n, i_valid && !o_stall, ctl.vld[0], "accepted transaction missing in first stage")
    `CBE_ASSERT_SAME(a_held_result_not_loaded, i_clk, i_rst_n, o_valid && i_stall, !ctl.load[NUM_STAGES-1], "held result overwritten")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic bezier evaluator testbench
// streams curve parameters through the evaluator with random input gaps and
// output stalls, rewrites the control points between phases while the block
// is idle, and checks every result against an exact power-basis evaluation
// ----------------------------------------------------------------------------
module testbench
    import cbe_pkg::*;
();

    localparam int TF           = T_FRAC_BITS_DEF;
    localparam int LONG_HOLD    = 40;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_ITEMS  = 150;
    localparam int CHUNK        = 50;

    localparam logic [T_W-1:0]       T_ONE          = T_W'(1) << TF;
    localparam logic [T_W-1:0]       T_MAX          = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = '1;
    localparam logic [PNT_W-1:0]     PNT_MAX        = {1'b0, {(PNT_W-1){1'b1}}};
    localparam logic [PNT_W-1:0]     PNT_MIN        = {1'b1, {(PNT_W-1){1'b0}}};

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic [ACC_W-1:0] acc_x;
        logic [ACC_W-1:0] acc_y;
    } curve_sample_t;

    class bezier_scoreboard;
        logic [PNT_W-1:0] ctrl_pt [8];
        curve_sample_t    expected_q [$];
        int unsigned      errors;

        function new();
            foreach (ctrl_pt[i]) ctrl_pt[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PNT_W-1:0] val);
            if (idx <= CFG_CTRL3_Y) begin
                ctrl_pt[idx] = val;
            end
        endfunction

        function void eval_axis(input logic [PNT_W-1:0] r0, r1, r2, r3,
                                input logic [T_W-1:0] t,
                                output logic [POS_W-1:0] pos,
                                output logic [VEL_W-1:0] vel,
                                output logic [ACC_W-1:0] acc);
            logic signed [127:0] p0, p1, p2, p3, u, ca, cb, cc, num;
            p0 = 128'(signed'(r0));
            p1 = 128'(signed'(r1));
            p2 = 128'(signed'(r2));
            p3 = 128'(signed'(r3));
            u  = {{(128-T_W){1'b0}}, t};
            ca = 3 * p1 - p0 - 3 * p2 + p3;
            cb = 3 * p0 - 6 * p1 + 3 * p2;
            cc = 3 * p1 - 3 * p0;

            num = ca * u * u * u + ((cb * u * u) <<< TF) + ((cc * u) <<< (2 * TF))
                + (p0 <<< (3 * TF));
            num = (num + (128'sd1 <<< (3 * TF - 1))) >>> (3 * TF);
            pos = num[POS_W-1:0];

            num = 3 * ca * u * u + ((2 * cb * u) <<< TF) + (cc <<< (2 * TF));
            num = (num + (128'sd1 <<< (2 * TF - 1))) >>> (2 * TF);
            vel = num[VEL_W-1:0];

            num = 6 * ca * u + ((2 * cb) <<< TF);
            num = (num + (128'sd1 <<< (TF - 1))) >>> TF;
            acc = num[ACC_W-1:0];
        endfunction

        function void note_input(logic [T_W-1:0] t);
            curve_sample_t  s;
            logic [T_W-1:0] u;
            u = (t > T_ONE) ? T_ONE : t;
            eval_axis(ctrl_pt[CFG_CTRL0_X], ctrl_pt[CFG_CTRL1_X], ctrl_pt[CFG_CTRL2_X],
                      ctrl_pt[CFG_CTRL3_X], u, s.pos_x, s.vel_x, s.acc_x);
            eval_axis(ctrl_pt[CFG_CTRL0_Y], ctrl_pt[CFG_CTRL1_Y], ctrl_pt[CFG_CTRL2_Y],
                      ctrl_pt[CFG_CTRL3_Y], u, s.pos_y, s.vel_y, s.acc_y);
            expected_q.push_back(s);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%h, actual 0x%h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(curve_sample_t got);
            curve_sample_t want;
            if (expected_q.size() == 0) begin
                $error("result transaction with no pending expectation");
                errors++;
            end else begin
                want = expected_q.pop_front();
                compare("pos_x", 64'(want.pos_x), 64'(got.pos_x));
                compare("pos_y", 64'(want.pos_y), 64'(got.pos_y));
                compare("vel_x", 64'(want.vel_x), 64'(got.vel_x));
                compare("vel_y", 64'(want.vel_y), 64'(got.vel_y));
                compare("acc_x", 64'(want.acc_x), 64'(got.acc_x));
                compare("acc_y", 64'(want.acc_y), 64'(got.acc_y));
            end
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic [T_W-1:0]          i_t_param   = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic signed [VEL_W-1:0] o_vel_x;
    logic signed [VEL_W-1:0] o_vel_y;
    logic signed [ACC_W-1:0] o_acc_x;
    logic signed [ACC_W-1:0] o_acc_y;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]    i_cfg_data  = '0;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    bezier_scoreboard sb = new();

    cubic_bezier_evaluator i_dut (.*);

    initial begin : clk_gen
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(64'd20_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_pos_x, o_pos_y, o_vel_x, o_vel_y, o_acc_x, o_acc_y});
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r, n;
        r = $urandom_range(99, 0);
        n = 0;
        if (!steady) begin
            if (r >= 97) n = $urandom_range(60, 20);
            else if (r >= 88) n = $urandom_range(12, 4);
            else if (r >= 55) n = $urandom_range(3, 1);
        end
        return n;
    endfunction

    function automatic logic [T_W-1:0] random_t();
        int unsigned    r;
        logic [T_W-1:0] t;
        r = $urandom_range(99, 0);
        if (r < 70) begin
            t = T_W'($urandom_range(T_ONE, 0));
        end else if (r < 80) begin
            case ($urandom_range(3, 0))
                0: t = '0;
                1: t = T_W'(1);
                2: t = T_W'(T_ONE - 1);
                default: t = T_ONE;
            endcase
        end else if (r < 90) begin
            t = T_W'($urandom_range(T_MAX, T_ONE + 1));
        end else begin
            t = T_W'($urandom);
        end
        return t;
    endfunction

    function automatic logic [PNT_W-1:0] rand_point();
        int unsigned      r;
        logic [31:0]      s;
        logic [PNT_W-1:0] v;
        r = $urandom_range(9, 0);
        s = $urandom;
        if (r < 4) v = s;
        else if (r < 7) v = {{8{s[23]}}, s[23:0]};
        else if (r < 8) v = PNT_MAX;
        else if (r < 9) v = PNT_MIN;
        else v = s[0] ? '0 : '1;
        return v;
    endfunction

    // receiver side stalls
    initial begin : rx_side
        int unsigned n;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = LONG_HOLD;
            end else begin
                n = pick_gap();
            end
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    task automatic send_t(input logic [T_W-1:0] t);
        i_valid   <= 1'b1;
        i_t_param <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(t);
    endtask

    task automatic pause_in(input int unsigned n);
        if (n != 0) begin
            i_valid   <= 1'b0;
            i_t_param <= T_W'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (NUM_STAGES + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_point(input int k, input logic [PNT_W-1:0] x,
                               input logic [PNT_W-1:0] y);
        write_reg(t_cfg_idx'(2 * k), x);
        write_reg(t_cfg_idx'(2 * k + 1), y);
    endtask

    task automatic run_edges();
        send_t('0);
        send_t(T_W'(1));
        send_t(T_ONE >> 1);
        send_t(T_W'(T_ONE - 1));
        send_t(T_ONE);
        send_t(T_W'(T_ONE + 1));
        send_t(T_MAX);
    endtask

    task automatic randomize_points(input bit all);
        for (int r = 0; r < 8; r++) begin
            if (all || $urandom_range(3, 0) != 0) begin
                write_reg(t_cfg_idx'(r), rand_point());
            end
        end
        if ($urandom_range(3, 0) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(255, 8)), $urandom);
        end
    endtask

    initial begin : stimulus
        int unsigned sent;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_t('0);
        send_t(T_ONE);
        settle();

        // half-way ties of both signs
        write_point(0, 32'sd4, -32'sd4);
        send_t(T_ONE >> 1);
        send_t('0);
        settle();

        for (int k = 0; k < 4; k++) write_point(k, PNT_MAX, PNT_MAX);
        write_reg(CFG_IDX_UNUSED, '0);
        run_edges();
        settle();

        for (int k = 0; k < 4; k++) write_point(k, PNT_MIN, PNT_MIN);
        run_edges();
        settle();

        for (int k = 0; k < 4; k++) begin
            write_point(k, k[0] ? PNT_MAX : PNT_MIN, k[0] ? PNT_MIN : PNT_MAX);
        end
        run_edges();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % PHASE_ITEMS == 0) begin
                settle();
                randomize_points(sent == 0);
            end
            if (sent % CHUNK == 0) begin
                steady = ($urandom_range(3, 0) == 0);
                if (sent == 300) begin
                    steady   = 1'b1;
                    hold_req = 1'b1;
                end
                if (sent == 1000) begin
                    settle();
                end
            end
            send_t(random_t());
            pause_in(pick_gap());
            sent++;
        end
        settle();

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
